// ----- src/wsz_pkg.sv -----
// Shared types, sizes and codes of the weekly slot zone scheduler.
// Used by every module of the block; depends on nothing.
package wsz_pkg;

  localparam int ZONE_COUNT    = 2;
  localparam int PROFILE_COUNT = 8;
  localparam int SLOT_COUNT    = 48;
  localparam int CMD_BITS      = 3;
  localparam int DAYS          = 7;

  localparam int HOUR_MAX   = 23;
  localparam int MINUTE_MAX = 59;
  localparam int HALF_HOUR  = 30;

  localparam int REQ_W  = 3;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int DAY_W  = 3;
  localparam int PROF_W = 3;
  localparam int SLOT_W = 6;
  localparam int CODE_W = 3;
  localparam int ZONE_W = 4;
  localparam int KIND_W = 2;

  localparam int MEM_DEPTH = PROFILE_COUNT * SLOT_COUNT;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int ZI_W      = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
  localparam int ZC_W      = $clog2(ZONE_COUNT + 1);

  // Both queues have a power-of-two depth so the pointers wrap by themselves.
  localparam int OPQ_DEPTH  = 2;
  localparam int OPQ_PTR_W  = $clog2(OPQ_DEPTH);
  localparam int OPQ_CNT_W  = $clog2(OPQ_DEPTH + 1);
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_FILL   = 3'd2,
    REQ_MAP    = 3'd3,
    REQ_ENABLE = 3'd4,
    REQ_APPLY  = 3'd5,
    REQ_QUERY  = 3'd6
  } req_e;

  typedef enum logic [2:0] {
    OP_TICK, OP_WRITE, OP_FILL, OP_MAP, OP_ENABLE, OP_APPLY, OP_QUERY, OP_REJECT
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    RK_SCHED, RK_QUERY, RK_DONE, RK_REJECT
  } res_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCHED_EN, CFG_DEFAULT_CMD
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_FILL, ST_ACK, ST_APPLY, ST_AEMIT, ST_QEMIT
  } state_e;

  // Decoded request as it travels from the front to the back.
  typedef struct packed {
    op_e              op;
    logic [SLOT_W-1:0] slot;
    logic [DAY_W-1:0]  day;
    logic [PROF_W-1:0] prof;
    logic [CODE_W-1:0] cmd;
    logic [CODE_W-1:0] night;
    logic [SLOT_W-1:0] nstart;
    logic [SLOT_W-1:0] nend;
    logic [ZI_W-1:0]   zone;
    logic              en;
    logic              ok;
  } op_t;

  typedef struct packed {
    res_kind_e         kind;
    logic [ZONE_W-1:0] zone;
    logic [CODE_W-1:0] cmd;
    logic              last;
  } res_t;

endpackage

// ----- src/wsz_front.sv -----
// Request front end: checks and decodes each input word, then queues it.
// Depends on wsz_pkg.
module wsz_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [wsz_pkg::REQ_W-1:0]     req_type_i,
  input  logic [wsz_pkg::HOUR_W-1:0]    hour_i,
  input  logic [wsz_pkg::MIN_W-1:0]     minute_i,
  input  logic [wsz_pkg::DAY_W-1:0]     day_of_week_i,
  input  logic [wsz_pkg::PROF_W-1:0]    profile_num_i,
  input  logic [wsz_pkg::SLOT_W-1:0]    slot_num_i,
  input  logic [wsz_pkg::CODE_W-1:0]    cmd_code_i,
  input  logic [wsz_pkg::CODE_W-1:0]    night_code_i,
  input  logic [wsz_pkg::SLOT_W-1:0]    night_start_i,
  input  logic [wsz_pkg::SLOT_W-1:0]    night_end_i,
  input  logic [wsz_pkg::ZONE_W-1:0]    zone_num_i,
  input  logic                          enable_bit_i,
  input  logic                          clear_busy_i,
  output logic                          op_valid_o,
  output wsz_pkg::op_t                  op_o,
  input  logic                          op_pop_i
);
  import wsz_pkg::*;

  op_t                  op_in;
  op_t                  q_mem [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OPQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OPQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                 accept;
  logic                 zone_ok, day_ok, prof_ok, slot_ok, tick_ok;
  logic [SLOT_W-1:0]    tick_slot;

  assign zone_ok = (zone_num_i != '0) && (zone_num_i <= ZONE_W'(ZONE_COUNT));
  assign day_ok  = day_of_week_i < DAY_W'(DAYS);
  assign prof_ok = {1'b0, profile_num_i} < (PROF_W + 1)'(PROFILE_COUNT);
  assign slot_ok = slot_num_i < SLOT_W'(SLOT_COUNT);
  assign tick_ok = (hour_i <= HOUR_W'(HOUR_MAX)) && (minute_i <= MIN_W'(MINUTE_MAX)) && day_ok;

  // Two slots per hour; the second half starts at minute thirty.
  assign tick_slot = {hour_i, 1'b0} + SLOT_W'(minute_i >= MIN_W'(HALF_HOUR));

  always_comb begin
    op_in        = '0;
    op_in.op     = OP_REJECT;
    op_in.slot   = slot_num_i;
    op_in.day    = day_of_week_i;
    op_in.prof   = profile_num_i;
    op_in.cmd    = cmd_code_i;
    op_in.night  = night_code_i;
    op_in.nstart = night_start_i;
    op_in.nend   = night_end_i;
    op_in.zone   = ZI_W'(zone_num_i - ZONE_W'(1));
    op_in.en     = enable_bit_i;
    op_in.ok     = zone_ok && day_ok && slot_ok;
    case (req_e'(req_type_i))
      REQ_TICK: begin
        if (tick_ok) begin
          op_in.op   = OP_TICK;
          op_in.slot = tick_slot;
        end
      end
      REQ_WRITE: begin
        if (prof_ok && slot_ok) op_in.op = OP_WRITE;
      end
      REQ_FILL: begin
        if (prof_ok) op_in.op = OP_FILL;
      end
      REQ_MAP: begin
        if (zone_ok && day_ok && prof_ok) op_in.op = OP_MAP;
      end
      REQ_ENABLE: begin
        if (zone_ok) op_in.op = OP_ENABLE;
      end
      REQ_APPLY: begin
        op_in.op = OP_APPLY;
      end
      REQ_QUERY: begin
        op_in.op = OP_QUERY;
      end
      default: begin
        op_in.op = OP_REJECT;
      end
    endcase
  end

  // The queue also reads as full while the profile memory is being cleared.
  assign full_o     = (cnt_q == OPQ_CNT_W'(OPQ_DEPTH)) || clear_busy_i;
  assign accept     = push_i && !full_o;
  assign op_valid_o = cnt_q != '0;
  assign op_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (accept) begin
      wr_ptr_d = wr_ptr_q + OPQ_PTR_W'(1);
    end
    if (op_pop_i) begin
      rd_ptr_d = rd_ptr_q + OPQ_PTR_W'(1);
    end
    case ({accept, op_pop_i})
      2'b10:   cnt_d = cnt_q + OPQ_CNT_W'(1);
      2'b01:   cnt_d = cnt_q - OPQ_CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_mem[wr_ptr_q] <= op_in;
    end
  end

endmodule

// ----- src/wsz_back.sv -----
// Request back end: profile memory, zone state and the sequencer that runs
// each decoded request and produces its result words. Depends on wsz_pkg.
module wsz_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           op_valid_i,
  input  wsz_pkg::op_t                   op_i,
  output logic                           op_pop_o,
  output logic                           clear_busy_o,
  input  logic                           res_full_i,
  output logic                           res_push_o,
  output wsz_pkg::res_t                  res_o,
  input  logic                           cfg_valid_i,
  input  wsz_pkg::cfg_idx_e              cfg_index_i,
  input  logic [wsz_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wsz_pkg::*;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_cnt_q, clr_cnt_d;
  logic [SLOT_W-1:0]   fill_cnt_q, fill_cnt_d;
  logic [ZC_W-1:0]     zc_q, zc_d;
  logic [SLOT_W-1:0]   cur_slot_q, cur_slot_d;
  logic [DAY_W-1:0]    cur_day_q, cur_day_d;
  logic [SLOT_W-1:0]   as_q, as_d;
  logic                as_none_q, as_none_d;
  logic [DAY_W-1:0]    ad_q, ad_d;
  logic                ad_none_q, ad_none_d;
  logic                sched_en_q, sched_en_d;
  logic [CODE_W-1:0]   def_cmd_q, def_cmd_d;
  logic [ZONE_COUNT-1:0] zone_en_q, zone_en_d;
  logic [PROF_W-1:0]   map_q [ZONE_COUNT][DAYS];
  logic [PROF_W-1:0]   map_d [ZONE_COUNT][DAYS];

  logic [CMD_BITS-1:0] mem [MEM_DEPTH];
  logic [CMD_BITS-1:0] rdata_q;
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [CMD_BITS-1:0] mem_wdata;

  logic [ZI_W-1:0]     zsel;
  logic [DAY_W-1:0]    dsel;
  logic [SLOT_W-1:0]   ssel;
  logic [PROF_W-1:0]   map_rd;
  logic [ADDR_W-1:0]   op_base;
  logic                is_night;
  logic                more_en;
  logic                tick_same;
  logic                fill_last;
  logic                zones_done;

  // One read port on the map: the apply walk or the request at the head.
  assign zsel   = (state_q == ST_APPLY) ? zc_q[ZI_W-1:0] : op_i.zone;
  assign dsel   = (state_q == ST_APPLY) ? cur_day_q : op_i.day;
  assign ssel   = (state_q == ST_APPLY) ? cur_slot_q : op_i.slot;
  assign map_rd = map_q[zsel][dsel];

  assign mem_raddr = ADDR_W'(map_rd * SLOT_COUNT) + ADDR_W'(ssel);
  assign op_base   = ADDR_W'(op_i.prof * SLOT_COUNT);

  // A night range whose end lies below its start wraps past midnight.
  assign is_night = (op_i.nstart <= op_i.nend)
                  ? (fill_cnt_q >= op_i.nstart && fill_cnt_q < op_i.nend)
                  : (fill_cnt_q >= op_i.nstart || fill_cnt_q < op_i.nend);

  assign tick_same = !as_none_q && (op_i.slot == as_q) && !ad_none_q && (op_i.day == ad_q);
  assign fill_last  = fill_cnt_q == SLOT_W'(SLOT_COUNT - 1);
  assign zones_done = zc_q == ZC_W'(ZONE_COUNT);

  always_comb begin
    more_en = 1'b0;
    for (int i = 0; i < ZONE_COUNT; i++) begin
      if (ZC_W'(i) > zc_q && zone_en_q[i]) more_en = 1'b1;
    end
  end

  assign clear_busy_o = state_q == ST_CLEAR;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == ADDR_W'(MEM_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (op_valid_i) begin
          case (op_i.op)
            OP_TICK: begin
              if (sched_en_q && !tick_same) state_d = ST_APPLY;
            end
            OP_APPLY: begin
              if (sched_en_q) state_d = ST_APPLY;
            end
            OP_FILL: begin
              state_d = ST_FILL;
            end
            OP_QUERY: begin
              if (op_i.ok) state_d = ST_QEMIT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_FILL: begin
        if (fill_last) state_d = ST_ACK;
      end
      ST_ACK: begin
        if (!res_full_i) state_d = ST_IDLE;
      end
      ST_APPLY: begin
        if (zones_done) begin
          state_d = ST_IDLE;
        end else if (zone_en_q[zc_q[ZI_W-1:0]]) begin
          state_d = ST_AEMIT;
        end
      end
      ST_AEMIT: begin
        if (!res_full_i) state_d = ST_APPLY;
      end
      ST_QEMIT: begin
        if (!res_full_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    fill_cnt_d = fill_cnt_q;
    zc_d       = zc_q;
    cur_slot_d = cur_slot_q;
    cur_day_d  = cur_day_q;
    as_d       = as_q;
    as_none_d  = as_none_q;
    ad_d       = ad_q;
    ad_none_d  = ad_none_q;
    sched_en_d = sched_en_q;
    def_cmd_d  = def_cmd_q;
    zone_en_d  = zone_en_q;
    map_d      = map_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = clr_cnt_q;
    mem_wdata  = '0;
    op_pop_o   = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    res_o.last = 1'b1;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (op_valid_i) begin
          case (op_i.op)
            OP_TICK: begin
              cur_slot_d = op_i.slot;
              cur_day_d  = op_i.day;
              zc_d       = '0;
              if (!sched_en_q || tick_same) op_pop_o = 1'b1;
            end
            OP_APPLY: begin
              zc_d = '0;
              if (!sched_en_q) op_pop_o = 1'b1;
            end
            OP_FILL: begin
              fill_cnt_d = '0;
            end
            OP_QUERY: begin
              if (op_i.ok) begin
                mem_re = 1'b1;
              end else if (!res_full_i) begin
                res_push_o = 1'b1;
                res_o.kind = RK_QUERY;
                res_o.cmd  = def_cmd_q;
                op_pop_o   = 1'b1;
              end
            end
            default: begin
              // Slot write, map, zone enable and rejection all answer with
              // one word and finish here.
              if (!res_full_i) begin
                res_push_o = 1'b1;
                res_o.kind = (op_i.op == OP_REJECT) ? RK_REJECT : RK_DONE;
                op_pop_o   = 1'b1;
                case (op_i.op)
                  OP_WRITE: begin
                    mem_we    = 1'b1;
                    mem_waddr = op_base + ADDR_W'(op_i.slot);
                    mem_wdata = CMD_BITS'(op_i.cmd);
                  end
                  OP_MAP: begin
                    map_d[op_i.zone][op_i.day] = op_i.prof;
                  end
                  OP_ENABLE: begin
                    zone_en_d[op_i.zone] = op_i.en;
                  end
                  default: begin
                  end
                endcase
              end
            end
          endcase
        end
      end
      ST_FILL: begin
        mem_we     = 1'b1;
        mem_waddr  = op_base + ADDR_W'(fill_cnt_q);
        mem_wdata  = is_night ? CMD_BITS'(op_i.night) : CMD_BITS'(op_i.cmd);
        fill_cnt_d = fill_cnt_q + SLOT_W'(1);
      end
      ST_ACK: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.kind = RK_DONE;
          op_pop_o   = 1'b1;
        end
      end
      ST_APPLY: begin
        if (zones_done) begin
          as_d      = cur_slot_q;
          as_none_d = 1'b0;
          ad_d      = cur_day_q;
          ad_none_d = 1'b0;
          op_pop_o  = 1'b1;
        end else if (zone_en_q[zc_q[ZI_W-1:0]]) begin
          mem_re = 1'b1;
        end else begin
          zc_d = zc_q + ZC_W'(1);
        end
      end
      ST_AEMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.kind = RK_SCHED;
          res_o.zone = ZONE_W'(zc_q) + ZONE_W'(1);
          res_o.cmd  = CODE_W'(rdata_q);
          res_o.last = !more_en;
          zc_d       = zc_q + ZC_W'(1);
        end
      end
      ST_QEMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.kind = RK_QUERY;
          res_o.cmd  = CODE_W'(rdata_q);
          op_pop_o   = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SCHED_EN: begin
          // Turning the scheduler on forgets the applied slot, so the next
          // tick applies.
          if (cfg_data_i[0] && !sched_en_q) as_none_d = 1'b1;
          sched_en_d = cfg_data_i[0];
        end
        CFG_DEFAULT_CMD: begin
          def_cmd_d = CODE_W'(cfg_data_i);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_cnt_q  <= '0;
      fill_cnt_q <= '0;
      zc_q       <= '0;
      cur_slot_q <= '0;
      cur_day_q  <= '0;
      as_q       <= '0;
      as_none_q  <= 1'b1;
      ad_q       <= '0;
      ad_none_q  <= 1'b1;
      sched_en_q <= 1'b0;
      def_cmd_q  <= '0;
      zone_en_q  <= '0;
      map_q      <= '{default: '0};
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      fill_cnt_q <= fill_cnt_d;
      zc_q       <= zc_d;
      cur_slot_q <= cur_slot_d;
      cur_day_q  <= cur_day_d;
      as_q       <= as_d;
      as_none_q  <= as_none_d;
      ad_q       <= ad_d;
      ad_none_q  <= ad_none_d;
      sched_en_q <= sched_en_d;
      def_cmd_q  <= def_cmd_d;
      zone_en_q  <= zone_en_d;
      map_q      <= map_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result word pushed into a full result queue");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop_o |-> op_valid_i)
    else $error("request popped from an empty request queue");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!op_pop_o && !res_push_o))
    else $error("request handled while the profile memory is being cleared");

  a_sched_zone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.kind == RK_SCHED) |->
      (res_o.zone != '0 && res_o.zone <= ZONE_W'(ZONE_COUNT)
       && zone_en_q[zc_q[ZI_W-1:0]]))
    else $error("scheduled command for a zone that is absent or disabled");

endmodule

// ----- src/wsz_resq.sv -----
// Result queue: holds finished result words until the receiver pops them.
// Depends on wsz_pkg.
module wsz_resq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wsz_pkg::res_t res_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output wsz_pkg::res_t res_o
);
  import wsz_pkg::*;

  res_t                  q_mem [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RESQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RESQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = cnt_q == RESQ_CNT_W'(RESQ_DEPTH);
  assign empty_o = cnt_q == '0;
  assign res_o   = q_mem[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + RESQ_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + RESQ_PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + RESQ_CNT_W'(1);
      2'b01:   cnt_d = cnt_q - RESQ_CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= res_i;
    end
  end

endmodule

// ----- src/weekly_slot_zone_scheduler.sv -----
// Top level of the weekly slot zone scheduler: request front, execution
// back end and result queue. Depends on wsz_pkg, wsz_front, wsz_back, wsz_resq.
//
// Requests enter through push/full: a word is taken on a clock edge with
// push high and full low. Results leave through empty/pop: the oldest word
// sits on the result ports while empty is low and is taken on an edge with
// pop high. A request yields one word, except a tick or apply that hits
// enabled zones (one word per enabled zone, the final one with last_flag),
// and a tick or apply that has nothing to do (no word).
// Configuration writes use cfg_valid_i/cfg_ready_o; ready is always high and
// writes are meant for an idle block.
// After reset the 384-entry profile memory is cleared one entry per cycle,
// and full stays high until the clear is done.
// The single-port sequencer in the back end runs one request at a time:
// write, map, enable, reject and an invalid query answer from the idle state;
// a valid query first reads the profile memory, then answers; a profile fill
// has a decode step, one memory write per slot and the answer; an apply walks
// every zone and emits a word for each enabled zone.
// A stalled receiver fills the two-word result queue, which halts the back
// end; the two-deep request queue then fills and raises full.
module weekly_slot_zone_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [wsz_pkg::REQ_W-1:0]      req_type_i,
  input  logic [wsz_pkg::HOUR_W-1:0]     hour_i,
  input  logic [wsz_pkg::MIN_W-1:0]      minute_i,
  input  logic [wsz_pkg::DAY_W-1:0]      day_of_week_i,
  input  logic [wsz_pkg::PROF_W-1:0]     profile_num_i,
  input  logic [wsz_pkg::SLOT_W-1:0]     slot_num_i,
  input  logic [wsz_pkg::CODE_W-1:0]     cmd_code_i,
  input  logic [wsz_pkg::CODE_W-1:0]     night_code_i,
  input  logic [wsz_pkg::SLOT_W-1:0]     night_start_i,
  input  logic [wsz_pkg::SLOT_W-1:0]     night_end_i,
  input  logic [wsz_pkg::ZONE_W-1:0]     zone_num_i,
  input  logic                           enable_bit_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [wsz_pkg::KIND_W-1:0]     result_kind_o,
  output logic [wsz_pkg::ZONE_W-1:0]     zone_out_o,
  output logic [wsz_pkg::CODE_W-1:0]     cmd_out_o,
  output logic                           last_flag_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wsz_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wsz_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wsz_pkg::*;

  logic op_valid;
  op_t  op_head;
  logic op_pop;
  logic clear_busy;
  logic res_full;
  logic res_push;
  res_t res_in;
  res_t res_head;

  assign cfg_ready_o = 1'b1;

  wsz_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .req_type_i    (req_type_i),
    .hour_i        (hour_i),
    .minute_i      (minute_i),
    .day_of_week_i (day_of_week_i),
    .profile_num_i (profile_num_i),
    .slot_num_i    (slot_num_i),
    .cmd_code_i    (cmd_code_i),
    .night_code_i  (night_code_i),
    .night_start_i (night_start_i),
    .night_end_i   (night_end_i),
    .zone_num_i    (zone_num_i),
    .enable_bit_i  (enable_bit_i),
    .clear_busy_i  (clear_busy),
    .op_valid_o    (op_valid),
    .op_o          (op_head),
    .op_pop_i      (op_pop)
  );

  wsz_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (op_valid),
    .op_i         (op_head),
    .op_pop_o     (op_pop),
    .clear_busy_o (clear_busy),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_idx_e'(cfg_index_i)),
    .cfg_data_i   (cfg_data_i)
  );

  wsz_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (res_head)
  );

  assign result_kind_o = res_head.kind;
  assign zone_out_o    = res_head.zone;
  assign cmd_out_o     = res_head.cmd;
  assign last_flag_o   = res_head.last;

endmodule

// ----- test/weekly_slot_zone_scheduler_tb.sv -----
// Self-checking testbench of the weekly slot zone scheduler.
// Holds its own prediction of the block; depends on wsz_pkg and the top level.
`timescale 1ns / 1ps

module weekly_slot_zone_scheduler_tb;
  import wsz_pkg::*;

  localparam int SLOT_TOTAL   = PROFILE_COUNT * SLOT_COUNT;
  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TIMEOUT_NS   = 3_000_000;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [DAY_W-1:0]  day;
    logic [PROF_W-1:0] prof;
    logic [SLOT_W-1:0] slot;
    logic [CODE_W-1:0] cmd;
    logic [CODE_W-1:0] night;
    logic [SLOT_W-1:0] nstart;
    logic [SLOT_W-1:0] nend;
    logic [ZONE_W-1:0] zone;
    logic              en;
  } sched_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic [KIND_W-1:0] result_kind_o;
  logic [ZONE_W-1:0] zone_out_o;
  logic [CODE_W-1:0] cmd_out_o;
  logic last_flag_o;
  sched_req_t drv_req = '0;

  // Shadow copy of the scheduler state.
  logic [CODE_W-1:0] slot_cmds [SLOT_TOTAL];
  logic [PROF_W-1:0] day_profile [ZONE_COUNT * DAYS];
  logic              zone_live [ZONE_COUNT];
  logic [SLOT_W-1:0] now_slot = '0;
  logic [DAY_W-1:0]  now_day = '0;
  logic [7:0]        done_slot = 8'hFF;
  logic [7:0]        done_day = 8'hFF;
  logic              sched_on = 1'b0;
  logic [CODE_W-1:0] fallback_cmd = '0;

  sched_req_t req_backlog[$];
  res_t       due_results[$];
  int         mismatches = 0;
  logic       no_idle = 1'b0;
  logic       hold_off_req = 1'b0;
  logic       hold_off_done = 1'b0;
  int         hold_count = 0;
  int         send_gap = 0;
  int         recv_gap = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  weekly_slot_zone_scheduler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .req_type_i    (drv_req.req_type),
    .hour_i        (drv_req.hour),
    .minute_i      (drv_req.minute),
    .day_of_week_i (drv_req.day),
    .profile_num_i (drv_req.prof),
    .slot_num_i    (drv_req.slot),
    .cmd_code_i    (drv_req.cmd),
    .night_code_i  (drv_req.night),
    .night_start_i (drv_req.nstart),
    .night_end_i   (drv_req.nend),
    .zone_num_i    (drv_req.zone),
    .enable_bit_i  (drv_req.en),
    .empty         (empty),
    .pop           (pop),
    .result_kind_o (result_kind_o),
    .zone_out_o    (zone_out_o),
    .cmd_out_o     (cmd_out_o),
    .last_flag_o   (last_flag_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic void owe_word(res_kind_e kind, logic [CODE_W-1:0] cmd);
    res_t w;
    w.kind = kind;
    w.zone = '0;
    w.cmd  = cmd;
    w.last = 1'b1;
    due_results.push_back(w);
  endfunction

  // One scheduled command per enabled zone, in rising zone order.
  function automatic void apply_zones();
    int   last_zone;
    res_t w;
    logic [PROF_W-1:0] p;
    last_zone = -1;
    for (int z = 0; z < ZONE_COUNT; z++)
      if (zone_live[z]) last_zone = z;
    for (int z = 0; z < ZONE_COUNT; z++) begin
      if (zone_live[z]) begin
        p = day_profile[z * DAYS + int'(now_day)];
        w.kind = RK_SCHED;
        w.zone = ZONE_W'(z + 1);
        w.cmd  = slot_cmds[int'(p) * SLOT_COUNT + int'(now_slot)];
        w.last = (z == last_zone);
        due_results.push_back(w);
      end
    end
    done_slot = {2'b00, now_slot};
    done_day  = {5'b00000, now_day};
  endfunction

  function automatic void step_schedule(sched_req_t r);
    logic zone_ok;
    logic is_night;
    logic [CODE_W-1:0] c;
    logic [PROF_W-1:0] p;
    zone_ok = (r.zone >= 1) && (r.zone <= ZONE_COUNT);
    case (r.req_type)
      REQ_TICK: begin
        if (r.hour > HOUR_MAX || r.minute > MINUTE_MAX || r.day >= DAYS) begin
          owe_word(RK_REJECT, '0);
        end else begin
          now_slot = SLOT_W'(r.hour * 2 + ((r.minute >= HALF_HOUR) ? 1 : 0));
          now_day  = r.day;
          if (sched_on && !({2'b00, now_slot} == done_slot && {5'b0, now_day} == done_day))
            apply_zones();
        end
      end
      REQ_WRITE: begin
        if (r.slot >= SLOT_COUNT) begin
          owe_word(RK_REJECT, '0);
        end else begin
          slot_cmds[int'(r.prof) * SLOT_COUNT + int'(r.slot)] = r.cmd;
          owe_word(RK_DONE, '0);
        end
      end
      REQ_FILL: begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
          // A night range with its end below its start wraps past midnight.
          if (r.nstart <= r.nend) is_night = (s >= r.nstart) && (s < r.nend);
          else is_night = (s >= r.nstart) || (s < r.nend);
          slot_cmds[int'(r.prof) * SLOT_COUNT + s] = is_night ? r.night : r.cmd;
        end
        owe_word(RK_DONE, '0);
      end
      REQ_MAP: begin
        if (!zone_ok || r.day >= DAYS) begin
          owe_word(RK_REJECT, '0);
        end else begin
          day_profile[(int'(r.zone) - 1) * DAYS + int'(r.day)] = r.prof;
          owe_word(RK_DONE, '0);
        end
      end
      REQ_ENABLE: begin
        if (!zone_ok) begin
          owe_word(RK_REJECT, '0);
        end else begin
          zone_live[int'(r.zone) - 1] = r.en;
          owe_word(RK_DONE, '0);
        end
      end
      REQ_APPLY: begin
        if (sched_on) apply_zones();
      end
      REQ_QUERY: begin
        c = fallback_cmd;
        if (zone_ok && r.day < DAYS && r.slot < SLOT_COUNT) begin
          p = day_profile[(int'(r.zone) - 1) * DAYS + int'(r.day)];
          c = slot_cmds[int'(p) * SLOT_COUNT + int'(r.slot)];
        end
        owe_word(RK_QUERY, c);
      end
      default: owe_word(RK_REJECT, '0);
    endcase
  endfunction

  // Driver: one word is offered at a time, with random gaps between words.
  always @(posedge clk_i) begin
    logic offer;
    if (rst_ni) begin
      offer = push;
      if (push && !full) begin
        step_schedule(drv_req);
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
        end else if (req_backlog.size() != 0) begin
          if (!no_idle && $urandom_range(0, 3) == 0) begin
            send_gap = $urandom_range(0, 4);
          end else begin
            drv_req <= req_backlog.pop_front();
            offer = 1'b1;
          end
        end
      end
      push <= offer;
    end
  end

  // Counts the cycles of the long receiver stall.
  always @(posedge clk_i) begin
    if (rst_ni && hold_off_req && !hold_off_done) begin
      hold_count <= hold_count + 1;
      if (hold_count + 1 >= HOLD_OFF_CYCLES) hold_off_done <= 1'b1;
    end
  end

  // Monitor: checks each word taken against the oldest one still owed.
  always @(posedge clk_i) begin
    res_t got, want;
    logic take;
    if (rst_ni) begin
      if (pop && !empty) begin
        got.kind = res_kind_e'(result_kind_o);
        got.zone = zone_out_o;
        got.cmd  = cmd_out_o;
        got.last = last_flag_o;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d zone %0d cmd %0d last %0d",
                   $time, got.kind, got.zone, got.cmd, got.last);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (got.kind != want.kind || got.zone != want.zone || got.cmd != want.cmd ||
              got.last != want.last) begin
            $display("%0t: result mismatch, expected kind %0d zone %0d cmd %0d last %0d,",
                     $time, want.kind, want.zone, want.cmd, want.last,
                     " got kind %0d zone %0d cmd %0d last %0d",
                     got.kind, got.zone, got.cmd, got.last);
            mismatches++;
          end
        end
      end
      if (hold_off_req && !hold_off_done) begin
        take = 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        take = 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        recv_gap = $urandom_range(0, 4);
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      pop <= take;
    end
  end

  function automatic sched_req_t blank_req(logic [REQ_W-1:0] kind);
    sched_req_t r;
    r = '0;
    r.req_type = kind;
    return r;
  endfunction

  function automatic sched_req_t tick_req(int h, int m, int d);
    sched_req_t r;
    r = blank_req(REQ_TICK);
    r.hour   = HOUR_W'(h);
    r.minute = MIN_W'(m);
    r.day    = DAY_W'(d);
    return r;
  endfunction

  // Mostly well-formed requests; one in ten keeps raw values in every field.
  function automatic sched_req_t random_req();
    sched_req_t r;
    int pick;
    r.req_type = REQ_W'($urandom);
    r.hour     = HOUR_W'($urandom);
    r.minute   = MIN_W'($urandom);
    r.day      = DAY_W'($urandom);
    r.prof     = PROF_W'($urandom);
    r.slot     = SLOT_W'($urandom);
    r.cmd      = CODE_W'($urandom);
    r.night    = CODE_W'($urandom);
    r.nstart   = SLOT_W'($urandom);
    r.nend     = SLOT_W'($urandom);
    r.zone     = ZONE_W'($urandom);
    r.en       = 1'($urandom);
    if ($urandom_range(0, 9) == 0) return r;
    pick = $urandom_range(0, 99);
    if (pick < 35)      r.req_type = REQ_TICK;
    else if (pick < 50) r.req_type = REQ_WRITE;
    else if (pick < 55) r.req_type = REQ_FILL;
    else if (pick < 65) r.req_type = REQ_MAP;
    else if (pick < 73) r.req_type = REQ_ENABLE;
    else if (pick < 80) r.req_type = REQ_APPLY;
    else                r.req_type = REQ_QUERY;
    r.hour   = HOUR_W'($urandom_range(0, HOUR_MAX));
    r.minute = MIN_W'($urandom_range(0, MINUTE_MAX));
    r.day    = DAY_W'($urandom_range(0, DAYS - 1));
    r.slot   = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
    r.nstart = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
    r.nend   = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
    if ($urandom_range(0, 7) != 0) r.zone = ZONE_W'($urandom_range(1, ZONE_COUNT));
    r.en = ($urandom_range(0, 3) != 0);
    return r;
  endfunction

  task automatic queue_random(int n);
    repeat (n) req_backlog.push_back(random_req());
  endtask

  // Waits until every word has been taken and owed, then lets the block go quiet.
  task automatic settle();
    while (req_backlog.size() != 0 || push || due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_SCHED_EN) begin
      // Turning the scheduler on forgets the last applied slot.
      if (data[0] && !sched_on) done_slot = 8'hFF;
      sched_on = data[0];
    end else begin
      fallback_cmd = data[CODE_W-1:0];
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    sched_req_t r;
    foreach (slot_cmds[i]) slot_cmds[i] = '0;
    foreach (day_profile[i]) day_profile[i] = '0;
    foreach (zone_live[i]) zone_live[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The block clears its profile memory after reset.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (full) @(posedge clk_i);

    write_cfg(CFG_SCHED_EN, 3'd1);
    write_cfg(CFG_DEFAULT_CMD, 3'd7);
    r = blank_req(REQ_ENABLE); r.zone = 1; r.en = 1; req_backlog.push_back(r);
    r = blank_req(REQ_ENABLE); r.zone = 2; r.en = 1; req_backlog.push_back(r);
    r = blank_req(REQ_MAP); r.zone = 1; r.day = 0; r.prof = 7; req_backlog.push_back(r);
    r = blank_req(REQ_FILL); r.prof = 7; r.cmd = 5; r.night = 2;
    r.nstart = 44; r.nend = 12; req_backlog.push_back(r);
    r = blank_req(REQ_FILL); r.prof = 0; r.cmd = 7; r.night = 0;
    r.nstart = 0; r.nend = 47; req_backlog.push_back(r);
    r = blank_req(REQ_FILL); r.prof = 3; r.cmd = 1; r.night = 6;
    r.nstart = 20; r.nend = 20; req_backlog.push_back(r);
    r = blank_req(REQ_WRITE); r.prof = 7; r.slot = 47; r.cmd = 7; req_backlog.push_back(r);
    r = blank_req(REQ_WRITE); r.prof = 0; r.slot = 0; r.cmd = 3; req_backlog.push_back(r);
    r = blank_req(REQ_WRITE); r.prof = 2; r.slot = 63; r.cmd = 4; req_backlog.push_back(r);
    req_backlog.push_back(tick_req(0, 0, 0));
    req_backlog.push_back(tick_req(0, 29, 0));
    req_backlog.push_back(tick_req(23, 59, 6));
    req_backlog.push_back(tick_req(12, 30, 3));
    req_backlog.push_back(tick_req(24, 0, 0));
    req_backlog.push_back(tick_req(0, 60, 0));
    req_backlog.push_back(tick_req(0, 0, 7));
    r = blank_req(REQ_MAP); r.zone = 0; r.day = 1; r.prof = 1; req_backlog.push_back(r);
    r = blank_req(REQ_MAP); r.zone = 1; r.day = 7; r.prof = 1; req_backlog.push_back(r);
    r = blank_req(REQ_ENABLE); r.zone = 15; r.en = 1; req_backlog.push_back(r);
    req_backlog.push_back(blank_req(REQ_APPLY));
    r = blank_req(REQ_QUERY); r.zone = 1; r.day = 0; r.slot = 47; req_backlog.push_back(r);
    r = blank_req(REQ_QUERY); r.zone = 0; r.day = 0; r.slot = 0; req_backlog.push_back(r);
    r = blank_req(REQ_QUERY); r.zone = 2; r.day = 7; r.slot = 5; req_backlog.push_back(r);
    r = blank_req(REQ_QUERY); r.zone = 2; r.day = 1; r.slot = 48; req_backlog.push_back(r);
    req_backlog.push_back(blank_req(3'd7));
    settle();

    // The receiver stalls for a long stretch while requests keep coming.
    write_cfg(CFG_DEFAULT_CMD, 3'd0);
    hold_off_req = 1'b1;
    queue_random(40);
    settle();

    // With the scheduler off, ticks only track time.
    write_cfg(CFG_SCHED_EN, 3'd0);
    write_cfg(CFG_DEFAULT_CMD, 3'd3);
    queue_random(30);
    settle();

    write_cfg(CFG_SCHED_EN, 3'd1);
    write_cfg(CFG_DEFAULT_CMD, 3'd5);
    queue_random(40);
    settle();

    write_cfg(CFG_SCHED_EN, 3'd1);
    write_cfg(CFG_DEFAULT_CMD, 3'd7);
    no_idle = 1'b1;
    queue_random(30);
    settle();

    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
